// File: hw/rtl/bdcg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdcg_pkg: shared types and constants of the binary dcg cutoff block
// Register indexes, reset values, queue operation and result formats.
// ----------------------------------------------------------------------------
package bdcg_pkg;

  localparam int unsigned MAX_RANK_DEF = 1024;
  localparam int unsigned Q_DEPTH_DEF  = 4;
  localparam int unsigned MAX_CUTOFFS  = 12;

  localparam logic [3:0]  CUTOFF_COUNT_RST = 4'd10;
  localparam logic [63:0] CUTOFFS_A_RST    = 64'h000F_000A_0005_0001;
  localparam logic [63:0] CUTOFFS_B_RST    = 64'h00C8_0064_001E_0014;
  localparam logic [63:0] CUTOFFS_C_RST    = 64'h0000_0000_03E8_01F4;

  // weight of rank one and the saturation point of a per-rank result
  localparam logic [16:0] UNIT_Q16 = 17'd65536;

  typedef enum logic [1:0] {
    REG_CUTOFF_COUNT = 2'd0,
    REG_CUTOFFS_A    = 2'd1,
    REG_CUTOFFS_B    = 2'd2,
    REG_CUTOFFS_C    = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    OP_EMIT  = 2'd0,
    OP_ADD   = 2'd1,
    OP_CLEAR = 2'd2
  } op_kind_t;

  // one unit of work handed from the front to the back
  typedef struct packed {
    op_kind_t    kind;
    logic [3:0]  slot;
    logic [15:0] cut;
    logic [15:0] rank;
    logic        last;
  } op_t;

  typedef struct packed {
    logic [3:0]  slot;
    logic [15:0] rank;
    logic [16:0] dcg;
    logic        last;
  } res_t;

  function automatic logic [15:0] cut_of(input logic [63:0] wa, input logic [63:0] wb,
                                         input logic [63:0] wc, input logic [3:0] slot);
    logic [63:0] w;
    w = '0;
    case (slot[3:2])
      2'd0:    w = wa;
      2'd1:    w = wb;
      2'd2:    w = wc;
      default: w = '0;
    endcase
    return w[{slot[1:0], 4'd0} +: 16];
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/bdcg_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdcg_queue: short operation queue between front and back
// Flip-flop fifo with a combinational head; push and pop in the same cycle.
// ----------------------------------------------------------------------------
module bdcg_queue
  import bdcg_pkg::*;
#(
  parameter int unsigned Depth = Q_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire op_t  din,
  output logic      full,
  input  wire logic pop,
  output op_t       dout,
  output logic      valid
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  op_t             mem_r [Depth];
  logic [PtrW-1:0] wr_r, wr_nxt;
  logic [PtrW-1:0] rd_r, rd_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign full    = (cnt_r == CntW'(Depth));
  assign valid   = (cnt_r != '0);
  assign dout    = mem_r[rd_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == PtrW'(Depth - 1)) ? '0 : wr_r + PtrW'(1);
    end
    if (do_pop) begin
      rd_nxt = (rd_r == PtrW'(Depth - 1)) ? '0 : rd_r + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
    if (do_push) begin
      mem_r[wr_r] <= din;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/bdcg_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdcg_front: item intake, rank tracking and cutoff matching
// Holds the configuration registers, counts ranks, matches cutoffs and turns
// each item into emit, add and clear operations for the back.
// ----------------------------------------------------------------------------
module bdcg_front
  import bdcg_pkg::*;
#(
  parameter int unsigned MaxRank = MAX_RANK_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,
  input  wire logic        in_tuser,
  input  wire logic        in_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  output logic             q_push,
  output op_t              q_op,
  input  wire logic        q_full
);

  localparam int unsigned RankW = $clog2(MaxRank + 1);

  typedef enum logic [2:0] {
    F_IDLE,
    F_HIT,
    F_ADD,
    F_FLUSH,
    F_CLEAR
  } fstate_t;

  fstate_t          state_r, state_nxt;
  logic [RankW-1:0] rank_r, rank_nxt;
  logic [3:0]       slot_r, slot_nxt;
  logic             done_r, done_nxt;
  logic [3:0]       cnt_r, cnt_nxt;
  logic [63:0]      wa_r, wa_nxt;
  logic [63:0]      wb_r, wb_nxt;
  logic [63:0]      wc_r, wc_nxt;
  logic [3:0]       hslot_r, hslot_nxt;
  logic [15:0]      hcut_r, hcut_nxt;
  logic             hlast_r, hlast_nxt;
  logic             add_r, add_nxt;
  logic [15:0]      add_rank_r, add_rank_nxt;
  logic             flush_r, flush_nxt;
  logic             eol_r, eol_nxt;

  logic [3:0]       used;
  logic [15:0]      cur_cut;
  logic             pend, rel_pos, hit, add, done1, flush, below_max;
  logic [3:0]       slot1, slot_inc;
  logic [RankW-1:0] rank_adv;

  assign in_tready = (state_r == F_IDLE);
  assign cfg_ready = 1'b1;

  assign used      = (cnt_r > 4'(MAX_CUTOFFS)) ? 4'(MAX_CUTOFFS) : cnt_r;
  assign cur_cut   = cut_of(wa_r, wb_r, wc_r, slot_r);
  assign pend      = !done_r && (slot_r < used);
  assign rel_pos   = !in_tdata[7] && (in_tdata != 8'd0);
  assign below_max = (rank_r < RankW'(MaxRank));
  assign hit       = in_tuser && pend && (16'(rank_r) == cur_cut);
  assign slot1     = hit ? slot_r + 4'd1 : slot_r;
  assign slot_inc  = slot_r + 4'd1;

  // a document with nothing pending closes the query for further work
  assign done1     = in_tuser ? (pend ? (hit && (slot1 >= used)) : 1'b1) : done_r;
  assign add       = in_tuser && pend && !done1 && rel_pos && below_max;
  assign rank_adv  = (in_tuser && below_max) ? rank_r + RankW'(1) : rank_r;
  assign flush     = in_tlast && !done1 && (slot1 < used);

  assign q_push = (state_r != F_IDLE) && !q_full;

  always_comb begin
    q_op = '{kind: OP_CLEAR, slot: 4'd0, cut: 16'd0, rank: 16'd0, last: 1'b0};
    case (state_r)
      F_HIT:   q_op = '{kind: OP_EMIT, slot: hslot_r, cut: hcut_r, rank: 16'd0,
                        last: hlast_r};
      F_ADD:   q_op = '{kind: OP_ADD, slot: 4'd0, cut: 16'd0, rank: add_rank_r,
                        last: 1'b0};
      F_FLUSH: q_op = '{kind: OP_EMIT, slot: slot_r, cut: cur_cut, rank: 16'd0,
                        last: (slot_inc >= used)};
      default: q_op = '{kind: OP_CLEAR, slot: 4'd0, cut: 16'd0, rank: 16'd0, last: 1'b0};
    endcase
  end

  always_comb begin
    state_nxt    = state_r;
    rank_nxt     = rank_r;
    slot_nxt     = slot_r;
    done_nxt     = done_r;
    cnt_nxt      = cnt_r;
    wa_nxt       = wa_r;
    wb_nxt       = wb_r;
    wc_nxt       = wc_r;
    hslot_nxt    = hslot_r;
    hcut_nxt     = hcut_r;
    hlast_nxt    = hlast_r;
    add_nxt      = add_r;
    add_rank_nxt = add_rank_r;
    flush_nxt    = flush_r;
    eol_nxt      = eol_r;

    if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_CUTOFF_COUNT: cnt_nxt = cfg_data[3:0];
        REG_CUTOFFS_A:    wa_nxt  = cfg_data;
        REG_CUTOFFS_B:    wb_nxt  = cfg_data;
        REG_CUTOFFS_C:    wc_nxt  = cfg_data;
      endcase
    end

    unique case (state_r)
      F_IDLE: begin
        if (in_tvalid) begin
          rank_nxt     = rank_adv;
          slot_nxt     = slot1;
          done_nxt     = done1;
          hslot_nxt    = slot_r;
          hcut_nxt     = cur_cut;
          hlast_nxt    = !flush;
          add_nxt      = add;
          add_rank_nxt = 16'(rank_r) + 16'd1;
          flush_nxt    = flush;
          eol_nxt      = in_tlast;
          if (hit) begin
            state_nxt = F_HIT;
          end else if (add) begin
            state_nxt = F_ADD;
          end else if (flush) begin
            state_nxt = F_FLUSH;
          end else if (in_tlast) begin
            state_nxt = F_CLEAR;
          end
        end
      end
      F_HIT: begin
        if (!q_full) begin
          if (add_r) begin
            state_nxt = F_ADD;
          end else if (flush_r) begin
            state_nxt = F_FLUSH;
          end else if (eol_r) begin
            state_nxt = F_CLEAR;
          end else begin
            state_nxt = F_IDLE;
          end
        end
      end
      F_ADD: begin
        if (!q_full) begin
          if (flush_r) begin
            state_nxt = F_FLUSH;
          end else if (eol_r) begin
            state_nxt = F_CLEAR;
          end else begin
            state_nxt = F_IDLE;
          end
        end
      end
      F_FLUSH: begin
        if (!q_full) begin
          slot_nxt = slot_inc;
          if (slot_inc >= used) begin
            state_nxt = F_CLEAR;
          end
        end
      end
      F_CLEAR: begin
        if (!q_full) begin
          rank_nxt  = '0;
          slot_nxt  = 4'd0;
          done_nxt  = 1'b0;
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      rank_r  <= '0;
      slot_r  <= 4'd0;
      done_r  <= 1'b0;
      cnt_r   <= CUTOFF_COUNT_RST;
      wa_r    <= CUTOFFS_A_RST;
      wb_r    <= CUTOFFS_B_RST;
      wc_r    <= CUTOFFS_C_RST;
      add_r   <= 1'b0;
      flush_r <= 1'b0;
      eol_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rank_r  <= rank_nxt;
      slot_r  <= slot_nxt;
      done_r  <= done_nxt;
      cnt_r   <= cnt_nxt;
      wa_r    <= wa_nxt;
      wb_r    <= wb_nxt;
      wc_r    <= wc_nxt;
      add_r   <= add_nxt;
      flush_r <= flush_nxt;
      eol_r   <= eol_nxt;
    end
    hslot_r    <= hslot_nxt;
    hcut_r     <= hcut_nxt;
    hlast_r    <= hlast_nxt;
    add_rank_r <= add_rank_nxt;
  end

endmodule
`default_nettype wire

// File: hw/rtl/bdcg_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdcg_back: gain accumulation and per-rank division
// Works one queued operation at a time: a squaring log2 unit and a shared
// bit-serial divider form rank weights and per-cutoff results.
// ----------------------------------------------------------------------------
module bdcg_back
  import bdcg_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic q_valid,
  input  wire op_t  q_op,
  output logic      q_pop,
  output logic      out_valid,
  input  wire logic out_ready,
  output res_t      out_res
);

  typedef enum logic [2:0] {
    B_IDLE,
    B_LOG,
    B_PREP,
    B_DIV,
    B_FIN,
    B_OUT
  } bstate_t;

  bstate_t     state_r, state_nxt;
  logic [31:0] gain_r, gain_nxt;
  logic        is_add_r, is_add_nxt;
  logic [3:0]  slot_r, slot_nxt;
  logic [15:0] cut_r, cut_nxt;
  logic        last_r, last_nxt;
  logic [31:0] x_r, x_nxt;
  logic [31:0] frac_r, frac_nxt;
  logic [3:0]  n_r, n_nxt;
  logic [37:0] rem_r, rem_nxt;
  logic [48:0] dq_r, dq_nxt;
  logic [35:0] dvs_r, dvs_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [16:0] dcg_r, dcg_nxt;
  logic        ov_r, ov_nxt;
  res_t        res_r, res_nxt;

  logic [63:0] prod;
  logic [31:0] sq;
  logic [3:0]  lead;
  logic [37:0] trial;
  logic        ge;
  logic [35:0] lg;
  logic [48:0] num;
  logic [32:0] sum_add;
  logic [32:0] sum_one;

  assign q_pop     = (state_r == B_IDLE) && q_valid;
  assign out_valid = ov_r;
  assign out_res   = res_r;

  assign prod    = x_r * x_r;
  assign sq      = prod[61:30];
  assign trial   = {rem_r[36:0], dq_r[48]};
  assign ge      = (trial >= {2'b00, dvs_r});
  assign lg      = {n_r, frac_r};
  assign num     = (49'd1 << 48) + 49'(lg[35:1]);
  assign sum_add = {1'b0, gain_r} + {16'd0, dq_r[16:0]};
  assign sum_one = {1'b0, gain_r} + {16'd0, UNIT_Q16};

  // position of the leading one of the rank
  always_comb begin
    lead = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (q_op.rank[i]) begin
        lead = 4'(i);
      end
    end
  end

  always_comb begin
    state_nxt  = state_r;
    gain_nxt   = gain_r;
    is_add_nxt = is_add_r;
    slot_nxt   = slot_r;
    cut_nxt    = cut_r;
    last_nxt   = last_r;
    x_nxt      = x_r;
    frac_nxt   = frac_r;
    n_nxt      = n_r;
    rem_nxt    = rem_r;
    dq_nxt     = dq_r;
    dvs_nxt    = dvs_r;
    cnt_nxt    = cnt_r;
    dcg_nxt    = dcg_r;
    ov_nxt     = ov_r && !out_ready;
    res_nxt    = res_r;

    unique case (state_r)
      B_IDLE: begin
        if (q_valid) begin
          unique case (q_op.kind)
            OP_EMIT: begin
              slot_nxt   = q_op.slot;
              cut_nxt    = q_op.cut;
              last_nxt   = q_op.last;
              is_add_nxt = 1'b0;
              if (q_op.cut == 16'd0) begin
                dcg_nxt   = 17'd0;
                state_nxt = B_OUT;
              end else begin
                rem_nxt   = 38'd0;
                dq_nxt    = {gain_r, 17'd0};
                dvs_nxt   = 36'(q_op.cut);
                cnt_nxt   = 5'd31;
                state_nxt = B_DIV;
              end
            end
            OP_ADD: begin
              if (q_op.rank <= 16'd1) begin
                gain_nxt = sum_one[32] ? 32'hFFFF_FFFF : sum_one[31:0];
              end else begin
                n_nxt     = lead;
                x_nxt     = 32'(q_op.rank) << (5'd30 - {1'b0, lead});
                frac_nxt  = 32'd0;
                cnt_nxt   = 5'd31;
                state_nxt = B_LOG;
              end
            end
            OP_CLEAR: gain_nxt = 32'd0;
            default:  gain_nxt = gain_r;
          endcase
        end
      end
      B_LOG: begin
        // one fraction bit of log2 per squaring
        x_nxt    = sq[31] ? {1'b0, sq[31:1]} : sq;
        frac_nxt = {frac_r[30:0], sq[31]};
        cnt_nxt  = cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          state_nxt = B_PREP;
        end
      end
      B_PREP: begin
        // quotient fits 17 bits, so the top of the dividend starts as remainder
        rem_nxt    = {6'd0, num[48:17]};
        dq_nxt     = {num[16:0], 32'd0};
        dvs_nxt    = lg;
        cnt_nxt    = 5'd16;
        is_add_nxt = 1'b1;
        state_nxt  = B_DIV;
      end
      B_DIV: begin
        rem_nxt = ge ? trial - {2'b00, dvs_r} : trial;
        dq_nxt  = {dq_r[47:0], ge};
        cnt_nxt = cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          state_nxt = B_FIN;
        end
      end
      B_FIN: begin
        if (is_add_r) begin
          gain_nxt  = sum_add[32] ? 32'hFFFF_FFFF : sum_add[31:0];
          state_nxt = B_IDLE;
        end else begin
          dcg_nxt   = (dq_r[31:0] > 32'(UNIT_Q16)) ? UNIT_Q16 : dq_r[16:0];
          state_nxt = B_OUT;
        end
      end
      B_OUT: begin
        if (!ov_r || out_ready) begin
          ov_nxt    = 1'b1;
          res_nxt   = '{slot: slot_r, rank: cut_r, dcg: dcg_r, last: last_r};
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      gain_r  <= 32'd0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      gain_r  <= gain_nxt;
      ov_r    <= ov_nxt;
    end
    is_add_r <= is_add_nxt;
    slot_r   <= slot_nxt;
    cut_r    <= cut_nxt;
    last_r   <= last_nxt;
    x_r      <= x_nxt;
    frac_r   <= frac_nxt;
    n_r      <= n_nxt;
    rem_r    <= rem_nxt;
    dq_r     <= dq_nxt;
    dvs_r    <= dvs_nxt;
    cnt_r    <= cnt_nxt;
    dcg_r    <= dcg_nxt;
    res_r    <= res_nxt;
  end

endmodule
`default_nettype wire

// File: hw/rtl/binary_dcg_at_cutoffs_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// binary_dcg_at_cutoffs_top: running binary dcg at configured rank cutoffs
// One beat on the in_ channel carries one ranked document: relevance in
// in_tdata, in_tuser set when a document is present, in_tlast on the last
// beat of a query. Each cutoff reached, or still open at the end of a query,
// gives one out_ beat with the cutoff slot in out_tuser, the cutoff rank and
// sum/cutoff (q1.16) in out_tdata; out_tlast marks an input beat's last result.
// The cfg_ channel writes the cutoff count and the three cutoff words; the user
// must write them only while the block is idle, which the block itself does
// not enforce; the channel is always ready. The front takes one beat and hands
// at most one operation per cycle to a short queue, and takes no new beat until
// every operation of the item is queued. The back runs one operation at a time:
// adding a weight beyond rank one takes dispatch, 32 squaring steps of the log2
// unit, set-up, 17 divider steps and the sum, a cutoff result 32 divider steps,
// which sets the sustained rate. Reset restores the register defaults and an
// empty query, with no clearing pass. A stalled receiver holds the output
// register; the back then waits and the queue, then the input, fill up.
// ----------------------------------------------------------------------------
module binary_dcg_at_cutoffs_top
  import bdcg_pkg::*;
#(
  parameter int unsigned MAX_RANK = MAX_RANK_DEF,
  parameter int unsigned Q_DEPTH  = Q_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] relevance
  input  wire logic        in_tuser,   // [0] has_document
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // [15:0] cutoff_rank, [32:16] dcg_per_rank
  output logic [3:0]       out_tuser,  // [3:0] cutoff_slot
  output logic             out_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  logic q_push, q_full, q_pop, q_valid;
  op_t  q_in, q_out;
  res_t res;

  bdcg_front #(
    .MaxRank (MAX_RANK)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_push    (q_push),
    .q_op      (q_in),
    .q_full    (q_full)
  );

  bdcg_queue #(
    .Depth (Q_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_in),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_out),
    .valid (q_valid)
  );

  bdcg_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_op      (q_out),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tdata = {7'd0, res.dcg, res.rank};
  assign out_tuser = res.slot;
  assign out_tlast = res.last;

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("front pushed into a full queue");

  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("back popped an empty queue");

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser < 4'(MAX_CUTOFFS)))
    else $error("result beat with a slot beyond the cutoff table");

  a_dcg_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[32:16] <= UNIT_Q16))
    else $error("per-rank result above one");

endmodule
`default_nettype wire

// File: tb/binary_dcg_at_cutoffs_checker.sv
// ----------------------------------------------------------------------------
// binary_dcg_at_cutoffs_checker: result predictor and scoreboard
// Watches the cfg_, in_ and out_ channels of the binary dcg block. Every
// accepted input beat advances a private copy of the query state and queues
// the cutoff results it should cause; every accepted output beat is compared
// field by field with the oldest queued result.
// ----------------------------------------------------------------------------
module binary_dcg_at_cutoffs_checker
  import bdcg_pkg::*;
#(
  parameter int unsigned MAX_RANK = MAX_RANK_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [7:0]  in_tdata,
  input  wire logic        in_tuser,
  input  wire logic        in_tlast,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [39:0] out_tdata,
  input  wire logic [3:0]  out_tuser,
  input  wire logic        out_tlast,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  output int unsigned      results_due,
  output int unsigned      mismatch_count
);

  // register shadows
  logic [3:0]  count_reg;
  logic [63:0] cut_words [3];

  // query state
  logic [16:0] docs_seen;
  logic [31:0] dcg_sum;
  logic [3:0]  slot_next;
  logic        cutoffs_done;

  res_t cutoff_results_due [$];

  // 1/log2(rank) in q1.16, log2 found bit by bit through repeated squaring
  function automatic logic [31:0] inv_log2_weight(input logic [16:0] r);
    int unsigned n;
    logic [63:0] x;
    logic [63:0] lg;
    if (r <= 17'd1) return 32'(UNIT_Q16);
    n = 0;
    while ((r >> (n + 1)) != 0) n++;
    x  = 64'(r) << (30 - n);
    lg = 64'(n) << 32;
    for (int k = 0; k < 32; k++) begin
      x = (x * x) >> 30;
      if (x >= (64'd1 << 31)) begin
        lg[31 - k] = 1'b1;
        x = x >> 1;
      end
    end
    return 32'(((64'd1 << 48) + (lg >> 1)) / lg);
  endfunction

  function automatic logic [15:0] cutoff_at(input logic [3:0] slot);
    logic [63:0] word;
    word = cut_words[slot >> 2];
    return word[16 * slot[1:0] +: 16];
  endfunction

  function automatic int unsigned slots_in_use();
    return (count_reg > MAX_CUTOFFS) ? MAX_CUTOFFS : int'(count_reg);
  endfunction

  function automatic bit cutoff_open();
    return !cutoffs_done && (slot_next < slots_in_use());
  endfunction

  function automatic logic [16:0] dcg_over_cutoff(input logic [15:0] cut);
    logic [31:0] q;
    if (cut == 16'd0) return 17'd0;
    q = dcg_sum / {16'd0, cut};
    return (q > 32'(UNIT_Q16)) ? UNIT_Q16 : q[16:0];
  endfunction

  task automatic queue_cutoff(input logic [3:0] slot);
    res_t beat;
    beat.slot = slot;
    beat.rank = cutoff_at(slot);
    beat.dcg  = dcg_over_cutoff(beat.rank);
    beat.last = 1'b0;
    cutoff_results_due.push_back(beat);
  endtask

  task automatic clear_query();
    docs_seen    = '0;
    dcg_sum      = '0;
    slot_next    = '0;
    cutoffs_done = 1'b0;
  endtask

  task automatic advance_dcg(input logic [7:0] rel, input logic doc, input logic eol);
    int unsigned n;
    logic [16:0] rank_before;
    logic [32:0] wide_sum;
    res_t        tail;
    n = 0;
    if (doc) begin
      rank_before = docs_seen;
      if (cutoff_open()) begin
        if (rank_before == {1'b0, cutoff_at(slot_next)}) begin
          queue_cutoff(slot_next);
          n++;
          slot_next = slot_next + 4'd1;
          if (slot_next >= slots_in_use()) cutoffs_done = 1'b1;
        end
        // binary gain: any positive relevance counts the same
        if (!cutoffs_done && rel != 8'd0 && !rel[7] && rank_before < MAX_RANK) begin
          wide_sum = {1'b0, dcg_sum} + {1'b0, inv_log2_weight(rank_before + 17'd1)};
          dcg_sum  = wide_sum[32] ? 32'hFFFF_FFFF : wide_sum[31:0];
        end
      end else begin
        cutoffs_done = 1'b1;
      end
      docs_seen = (rank_before < MAX_RANK) ? rank_before + 17'd1 : 17'(MAX_RANK);
    end
    if (eol) begin
      while (cutoff_open() && n < MAX_CUTOFFS) begin
        queue_cutoff(slot_next);
        n++;
        slot_next = slot_next + 4'd1;
      end
      clear_query();
    end
    if (n > 0) begin
      tail = cutoff_results_due.pop_back();
      tail.last = 1'b1;
      cutoff_results_due.push_back(tail);
    end
  endtask

  task automatic check_cutoff_beat();
    res_t want;
    if (cutoff_results_due.size() == 0) begin
      $display("%0t: unexpected result beat: slot %0d rank %0d dcg %0d last %0d",
               $time, out_tuser, out_tdata[15:0], out_tdata[32:16], out_tlast);
      mismatch_count++;
    end else begin
      want = cutoff_results_due.pop_front();
      if (out_tuser !== want.slot || out_tdata[15:0] !== want.rank ||
          out_tdata[32:16] !== want.dcg || out_tlast !== want.last) begin
        $display("%0t: result mismatch: expected slot %0d rank %0d dcg %0d last %0d",
                 $time, want.slot, want.rank, want.dcg, want.last);
        $display("%0t:                  actual slot %0d rank %0d dcg %0d last %0d",
                 $time, out_tuser, out_tdata[15:0], out_tdata[32:16], out_tlast);
        mismatch_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      count_reg    = CUTOFF_COUNT_RST;
      cut_words[0] = CUTOFFS_A_RST;
      cut_words[1] = CUTOFFS_B_RST;
      cut_words[2] = CUTOFFS_C_RST;
      clear_query();
      cutoff_results_due.delete();
      mismatch_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (reg_idx_t'(cfg_index))
          REG_CUTOFF_COUNT: count_reg    = cfg_data[3:0];
          REG_CUTOFFS_A:    cut_words[0] = cfg_data;
          REG_CUTOFFS_B:    cut_words[1] = cfg_data;
          REG_CUTOFFS_C:    cut_words[2] = cfg_data;
        endcase
      end
      if (in_tvalid && in_tready) advance_dcg(in_tdata, in_tuser, in_tlast);
      if (out_tvalid && out_tready) check_cutoff_beat();
    end
    results_due = cutoff_results_due.size();
  end

endmodule

// File: tb/tb_binary_dcg_at_cutoffs_top.sv
// ----------------------------------------------------------------------------
// tb_binary_dcg_at_cutoffs_top: stimulus and verdict for the binary dcg block
// Drives directed queries over the default and corner cutoff settings, then
// random cutoff settings with random queries. Both sides idle in random
// bursts but in the last phase; the receiver once holds off long enough to
// back the block up. Checking is done by the checker beside the block.
// ----------------------------------------------------------------------------
module tb_binary_dcg_at_cutoffs_top;
  import bdcg_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 400;
  localparam int unsigned HOLD_CYCLES   = 600;
  localparam int unsigned PHASE_ITEMS   = 40;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tuser;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic [3:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;

  int unsigned results_due;
  int unsigned mismatch_count;

  bit          tx_gaps;
  bit          rx_gaps;
  bit          rx_hold_req;
  int unsigned items_sent;

  always #5 clk = ~clk;

  binary_dcg_at_cutoffs_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  binary_dcg_at_cutoffs_checker u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .in_tlast       (in_tlast),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .out_tlast      (out_tlast),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .results_due    (results_due),
    .mismatch_count (mismatch_count)
  );

  function automatic logic [7:0] any_relevance();
    return $urandom_range(0, 1) ? 8'($urandom_range(1, 127)) : 8'($urandom_range(0, 255));
  endfunction

  task automatic send_item(input logic [7:0] rel, input logic doc, input logic eol);
    int unsigned gap;
    if (tx_gaps && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 12);
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= rel;
    in_tuser  <= doc;
    in_tlast  <= eol;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  // sender stops until every result has come and the back end is quiet
  task automatic drain_and_settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (results_due != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [63:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_gaps(input bit tx, input bit rx);
    @(posedge clk);
    tx_gaps = tx;
    rx_gaps = rx;
  endtask

  task automatic load_random_cutoffs();
    logic [15:0] cut [12];
    logic [63:0] word;
    int unsigned c;
    c = $urandom_range(0, 2);
    for (int s = 0; s < 12; s++) begin
      cut[s] = 16'(c);
      c += $urandom_range(1, 5);
    end
    if ($urandom_range(0, 7) == 0) write_reg(REG_CUTOFF_COUNT, 64'($urandom_range(0, 15)));
    else write_reg(REG_CUTOFF_COUNT, 64'($urandom_range(1, 12)));
    for (int j = 0; j < 3; j++) begin
      word = {cut[4 * j + 3], cut[4 * j + 2], cut[4 * j + 1], cut[4 * j]};
      if ($urandom_range(0, 4) == 0) word = {$urandom, $urandom};
      write_reg(reg_idx_t'(j + 1), word);
    end
  endtask

  task automatic run_query();
    int unsigned docs;
    bit end_on_doc;
    docs = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 12);
    end_on_doc = (docs != 0) && $urandom_range(0, 1);
    for (int k = 0; k < docs; k++) begin
      if ($urandom_range(0, 15) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(any_relevance(), 1'b1, end_on_doc && (k == docs - 1));
    end
    if (!end_on_doc) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  // receiver: random stall bursts, or one long hold-off on request
  initial begin : receiver
    int unsigned stall;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        rx_hold_req = 1'b0;
      end else if (rx_gaps && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        stall = $urandom_range(1, 12);
        repeat (stall - 1) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int unsigned phase_start;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = 1'b0;
    in_tlast    = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    tx_gaps     = 1'b1;
    rx_gaps     = 1'b1;
    rx_hold_req = 1'b0;
    items_sent  = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    // default cutoffs: extremes of relevance, a noise beat, flush at end of list
    send_item(8'h7F, 1'b1, 1'b0);
    send_item(8'h80, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'h01, 1'b1, 1'b0);
    send_item(8'h3C, 1'b0, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h7F, 1'b1, 1'b1);
    // empty list closed by a bare marker gives zeros
    send_item(8'h55, 1'b0, 1'b1);
    // single document list
    send_item(8'h01, 1'b1, 1'b1);

    // no cutoffs in use
    drain_and_settle();
    write_reg(REG_CUTOFF_COUNT, 64'd0);
    send_item(8'h05, 1'b1, 1'b0);
    send_item(8'h03, 1'b1, 1'b1);

    // count above the maximum, zero cutoff, duplicate, unordered, all-ones
    drain_and_settle();
    write_reg(REG_CUTOFF_COUNT, 64'd15);
    write_reg(REG_CUTOFFS_A, 64'hFFFF_0001_0003_0000);
    write_reg(REG_CUTOFFS_B, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_CUTOFFS_C, 64'h0000_0000_0000_0000);
    repeat (5) send_item(8'h7F, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);

    // count lowered in the middle of a query
    drain_and_settle();
    write_reg(REG_CUTOFF_COUNT, 64'd12);
    write_reg(REG_CUTOFFS_A, 64'h0004_0003_0002_0001);
    write_reg(REG_CUTOFFS_B, 64'h0008_0007_0006_0005);
    write_reg(REG_CUTOFFS_C, 64'h000C_000B_000A_0009);
    repeat (4) send_item(8'h20, 1'b1, 1'b0);
    drain_and_settle();
    write_reg(REG_CUTOFF_COUNT, 64'd2);
    send_item(8'h20, 1'b1, 1'b0);
    send_item(8'h20, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);

    // random cutoff settings and queries
    for (int ph = 0; ph < 6; ph++) begin
      drain_and_settle();
      load_random_cutoffs();
      if (ph == 5) set_gaps(1'b0, 1'b0);
      else set_gaps(1'b1, 1'b1);
      if (ph == 2) begin
        @(posedge clk);
        rx_hold_req = 1'b1;
      end
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) run_query();
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (results_due != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && results_due == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #6_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/bdcg_pkg.sv
hw/rtl/bdcg_queue.sv
hw/rtl/bdcg_front.sv
hw/rtl/bdcg_back.sv
hw/rtl/binary_dcg_at_cutoffs_top.sv
tb/binary_dcg_at_cutoffs_checker.sv
tb/tb_binary_dcg_at_cutoffs_top.sv
